/* rtl/stwa_pkg.sv */
// Shared types, microprogram and gain table for the stereo widener with auto-pan.
`default_nettype none

package stwa_pkg;

    // Fixed field widths.
    localparam int GAIN_W = 15;
    localparam int PAN_W  = 7;
    localparam int LFO_W  = 16;
    localparam int STEP_W = 4;

    typedef logic [STEP_W-1:0] t_step;

    // Configuration register indexes on the write port.
    typedef enum logic [1:0] {
        CFG_WIDEN,
        CFG_AUTOPAN,
        CFG_PAN,
        CFG_WIDTH
    } t_cfg_reg;

    // Datapath operations carried by the control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_WD,
        OP_SUM_T,
        OP_MUL_ROM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_MUL_START,
        OP_MAC_END,
        OP_MUL_RECIP,
        OP_MUL_WT,
        OP_MUL_X,
        OP_EMIT
    } t_op;

    // Jump conditions: the jump is taken when the condition holds.
    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_ITEM,
        C_NO_WIDEN,
        C_NO_AUTOPAN,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // Status flags that the sequencer tests.
    typedef struct packed {
        logic item_valid;
        logic widen;
        logic autopan;
        logic div_more;
        logic out_busy;
    } t_stat;

    // Per-lane coefficients selected by the top level.
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [PAN_W-1:0]  weight;
        logic [PAN_W-1:0]  width;
        logic [LFO_W-1:0]  lfo_start;
        logic [LFO_W-1:0]  lfo_end;
    } t_coef;

    // Program addresses.
    localparam t_step ST_WAIT       = 4'd0;
    localparam t_step ST_W_DIFF     = 4'd1;
    localparam t_step ST_W_SUM      = 4'd2;
    localparam t_step ST_W_GAIN     = 4'd3;
    localparam t_step ST_W_DINIT    = 4'd4;
    localparam t_step ST_W_DLOOP    = 4'd5;
    localparam t_step ST_W_DDONE    = 4'd6;
    localparam t_step ST_P_START    = 4'd7;
    localparam t_step ST_P_END      = 4'd8;
    localparam t_step ST_P_RECIP    = 4'd9;
    localparam t_step ST_P_WEIGHT   = 4'd10;
    localparam t_step ST_P_SAMPLE   = 4'd11;
    localparam t_step ST_P_DINIT    = 4'd12;
    localparam t_step ST_P_DLOOP    = 4'd13;
    localparam t_step ST_P_DDONE    = 4'd14;
    localparam t_step ST_EMIT       = 4'd15;

    // Microprogram: one control word per step. Without a jump the step
    // counter advances by one; from the last step it wraps to the wait step.
    function automatic t_ctrl prog_word(t_step step);
        t_ctrl w;
        w = '{op: OP_NONE, cond: C_NEVER, target: ST_WAIT};
        unique case (step)
            ST_WAIT:     w = '{op: OP_LOAD,      cond: C_NO_ITEM,    target: ST_WAIT};
            ST_W_DIFF:   w = '{op: OP_MUL_WD,    cond: C_NO_WIDEN,   target: ST_P_START};
            ST_W_SUM:    w = '{op: OP_SUM_T,     cond: C_NEVER,      target: ST_WAIT};
            ST_W_GAIN:   w = '{op: OP_MUL_ROM,   cond: C_NEVER,      target: ST_WAIT};
            ST_W_DINIT:  w = '{op: OP_DIV_INIT,  cond: C_NEVER,      target: ST_WAIT};
            ST_W_DLOOP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,   target: ST_W_DLOOP};
            ST_W_DDONE:  w = '{op: OP_DIV_DONE,  cond: C_NEVER,      target: ST_WAIT};
            ST_P_START:  w = '{op: OP_MUL_START, cond: C_NO_AUTOPAN, target: ST_EMIT};
            ST_P_END:    w = '{op: OP_MAC_END,   cond: C_NEVER,      target: ST_WAIT};
            ST_P_RECIP:  w = '{op: OP_MUL_RECIP, cond: C_NEVER,      target: ST_WAIT};
            ST_P_WEIGHT: w = '{op: OP_MUL_WT,    cond: C_NEVER,      target: ST_WAIT};
            ST_P_SAMPLE: w = '{op: OP_MUL_X,     cond: C_NEVER,      target: ST_WAIT};
            ST_P_DINIT:  w = '{op: OP_DIV_INIT,  cond: C_NEVER,      target: ST_WAIT};
            ST_P_DLOOP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,   target: ST_P_DLOOP};
            ST_P_DDONE:  w = '{op: OP_DIV_DONE,  cond: C_NEVER,      target: ST_WAIT};
            ST_EMIT:     w = '{op: OP_EMIT,      cond: C_OUT_BUSY,   target: ST_EMIT};
        endcase
        return w;
    endfunction

    // Quarter-sine gain table, Q0.15, built at elaboration from a
    // truncating Taylor series in Q2.30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [127:0][GAIN_W-1:0] sin_table();
        logic [127:0][GAIN_W-1:0] tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        int k;
        for (k = 0; k < 128; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / 64'd127;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - term;
            sum  = (sum + 64'd16384) >> 15;
            if (sum > 64'd32767) begin
                sum = 64'd32767;
            end
            tab[k] = sum[GAIN_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [127:0][GAIN_W-1:0] SIN_TABLE = sin_table();

endpackage

`default_nettype wire

/* rtl/stwa_seq.sv */
// Microcode sequencer: step counter, program table and conditional jumps.
`default_nettype none

module stwa_seq
    import stwa_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_step r_step;
    t_step n_step;
    t_ctrl ctrl;
    logic  take_jump;

    // Fetch the control word of the current step.
    assign ctrl   = prog_word(r_step);
    assign o_ctrl = ctrl;

    // Evaluate the jump condition and pick the next step.
    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:      take_jump = 1'b0;
            C_NO_ITEM:    take_jump = ~i_stat.item_valid;
            C_NO_WIDEN:   take_jump = ~i_stat.widen;
            C_NO_AUTOPAN: take_jump = ~i_stat.autopan;
            C_DIV_MORE:   take_jump = i_stat.div_more;
            C_OUT_BUSY:   take_jump = i_stat.out_busy;
            default:      take_jump = 1'b0;
        endcase
        if (take_jump) begin
            n_step = ctrl.target;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

/* rtl/stwa_lane.sv */
// One channel's datapath: shared multiplier, accumulator and rounding divider.
`default_nettype none

module stwa_lane
    import stwa_pkg::*;
#(
    parameter int BLOCK_LEN   = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  wire                                   i_clk,
    input  t_op                                   i_op,
    input  wire  signed [SAMPLE_BITS-1:0]         i_sample,
    input  wire  signed [SAMPLE_BITS+2:0]         i_other,
    input  t_coef                                 i_coef,
    input  wire  [$clog2(BLOCK_LEN)-1:0]          i_idx,
    output logic signed [SAMPLE_BITS+2:0]         o_x,
    output logic [SAMPLE_BITS-1:0]                o_sat,
    output logic                                  o_div_more
);

    localparam int XW = SAMPLE_BITS + 3;
    localparam int DW = XW + 1;
    localparam int IW = $clog2(BLOCK_LEN);
    localparam int RK = 16 + 2 * IW;
    localparam int MA = (SAMPLE_BITS + 11 > 17 + IW) ? SAMPLE_BITS + 11 : 17 + IW;
    localparam int MB = (23 > 17 + IW) ? 23 : 17 + IW;
    localparam int PW = MA + MB + 1;
    localparam int RW = PW - 8;
    localparam int QW = SAMPLE_BITS + 2;
    localparam int DIGIT = 14;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << RK) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);
    localparam logic [MB-1:0] RECIP = RECIP_WIDE[MB-1:0];
    localparam logic [PW-1:0] DIV_BIAS = PW'(127 * 32768);
    localparam logic [RW-1:0] DIGIT_MAX = RW'((1 << DIGIT) - 1);

    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] n_x;
    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] n_acc;
    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        n_rem;
    logic [QW-1:0]        r_q;
    logic [QW-1:0]        n_q;
    logic                 r_neg;
    logic                 n_neg;

    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] sum;
    logic signed [PW-1:0] sum_ext;
    logic [IW:0]          b_minus_i;
    logic [LFO_W-1:0]     lfo_gain;
    logic signed [MA-1:0] mult_a;
    logic [MB-1:0]        mult_b;
    logic signed [PW-1:0] prod;
    logic [PW-1:0]        mag;
    logic [PW-1:0]        biased;
    logic [PW-17:0]       scaled;
    logic [RW-1:0]        rem_init;
    logic [RW-DIGIT-1:0]  rem_hi;
    logic [RW-1:0]        rem_step;
    logic [QW-1:0]        q_step;
    logic [QW-1:0]        q_fin;
    logic signed [XW-1:0] x_fin;
    logic [XW-SAMPLE_BITS:0] x_top;

    // Mid/side terms, interpolation weight and the LFO gain slice.
    always_comb begin
        diff      = {r_x[XW-1], r_x} - {i_other[XW-1], i_other};
        sum       = {r_x[XW-1], r_x} + {i_other[XW-1], i_other};
        sum_ext   = {{(PW-DW){sum[DW-1]}}, sum};
        b_minus_i = (IW+1)'(BLOCK_LEN) - {1'b0, i_idx};
        lfo_gain  = r_acc[RK+LFO_W-1:RK];
    end

    // Multiplier operand selection.
    always_comb begin
        mult_a = '0;
        mult_b = '0;
        unique case (i_op)
            OP_MUL_WD: begin
                mult_a = {{(MA-DW){diff[DW-1]}}, diff};
                mult_b = MB'(i_coef.width);
            end
            OP_MUL_ROM: begin
                mult_a = r_acc[MA-1:0];
                mult_b = MB'(i_coef.gain);
            end
            OP_MUL_START: begin
                mult_a = MA'(i_coef.lfo_start);
                mult_b = MB'(b_minus_i);
            end
            OP_MAC_END: begin
                mult_a = MA'(i_coef.lfo_end);
                mult_b = MB'(i_idx);
            end
            OP_MUL_RECIP: begin
                mult_a = r_acc[MA-1:0];
                mult_b = RECIP;
            end
            OP_MUL_WT: begin
                mult_a = MA'(lfo_gain);
                mult_b = MB'(i_coef.weight);
            end
            OP_MUL_X: begin
                mult_a = {{(MA-XW){r_x[XW-1]}}, r_x};
                mult_b = r_acc[MB-1:0];
            end
            default: begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign prod = mult_a * $signed({1'b0, mult_b});

    // Rounding divide by 127*65536: bias and drop 16 bits, then divide by 127
    // as a multiply by 129 and digit folding modulo 2^14-1.
    always_comb begin
        mag      = r_acc[PW-1] ? PW'(-r_acc) : PW'(r_acc);
        biased   = mag + DIV_BIAS;
        scaled   = biased[PW-1:16];
        rem_init = RW'({scaled, 7'b0}) + RW'(scaled);
        rem_hi   = r_rem[RW-1:DIGIT];
        rem_step = RW'(r_rem[DIGIT-1:0]) + RW'(rem_hi);
        q_step   = r_q + rem_hi[QW-1:0];
        q_fin    = r_q + QW'(r_rem == DIGIT_MAX);
        x_fin    = r_neg ? XW'(0) - XW'({1'b0, q_fin}) : XW'({1'b0, q_fin});
    end

    // Next state of the lane registers.
    always_comb begin
        n_x   = r_x;
        n_acc = r_acc;
        n_rem = r_rem;
        n_q   = r_q;
        n_neg = r_neg;
        unique case (i_op)
            OP_LOAD:      n_x = {{(XW-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
            OP_SUM_T:     n_acc = (sum_ext <<< 7) - sum_ext + (r_acc <<< 2);
            OP_MAC_END:   n_acc = r_acc + prod;
            OP_MUL_WD,
            OP_MUL_ROM,
            OP_MUL_START,
            OP_MUL_RECIP,
            OP_MUL_WT,
            OP_MUL_X:     n_acc = prod;
            OP_DIV_INIT: begin
                n_neg = r_acc[PW-1];
                n_rem = rem_init;
                n_q   = '0;
            end
            OP_DIV_STEP: begin
                n_rem = rem_step;
                n_q   = q_step;
            end
            OP_DIV_DONE:  n_x = x_fin;
            default: begin
                n_x = r_x;
            end
        endcase
    end

    // Lane registers hold payload only.
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_neg <= n_neg;
    end

    // Saturate the working value to the sample width.
    always_comb begin
        x_top = r_x[XW-1:SAMPLE_BITS-1];
        if ((&x_top) || !(|x_top)) begin
            o_sat = r_x[SAMPLE_BITS-1:0];
        end else if (r_x[XW-1]) begin
            o_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign o_x        = r_x;
    assign o_div_more = |rem_hi;

endmodule

`default_nettype wire

/* rtl/stereo_widener_autopan.sv */
// Top level of the stereo widener with auto-pan: handshakes, registers and lanes.
//
// Usage: one beat on the input channel (i_valid, o_stall) carries a stereo
// sample pair and the two LFO end values; one beat on the output channel
// (o_valid, i_stall) carries the processed pair. Settings are written on the
// plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle.
// A microcoded sequencer drives two identical lanes, one per channel, each
// with one multiplier and an iterative divide by 127*65536. With both stages
// off only the stage heads of widening and auto-pan lie between the wait and
// emit steps. Widening adds its sum, gain and divide steps and auto-pan its
// LFO end, reciprocal, weight, sample and divide steps; each divide folds until
// no remainder has a high digit left. The emit step registers the result.
// o_stall is low only in the wait step, so one pair is processed at a time;
// the next pair is accepted in the cycle after the result is registered,
// while that result may still wait in the output register.
// When the receiver stalls, the output beat holds and the sequencer waits
// in its last step until the output register is free. Reset clears the
// sequencer, the block position, the LFO endpoints and the output valid and
// loads the register defaults (auto-pan on, pan centered, widening off).
`default_nettype none

module stereo_widener_autopan
    import stwa_pkg::*;
#(
    parameter int BLOCK_LEN   = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  signed [SAMPLE_BITS-1:0] i_left_in,
    input  wire  signed [SAMPLE_BITS-1:0] i_right_in,
    input  wire  [LFO_W-1:0]             i_lfo_left_next,
    input  wire  [LFO_W-1:0]             i_lfo_right_next,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_idx,
    input  wire  [PAN_W-1:0]             i_cfg_data
);

    localparam int IW = $clog2(BLOCK_LEN);
    localparam int XW = SAMPLE_BITS + 3;

    logic              r_widen;
    logic              r_autopan;
    logic [PAN_W-1:0]  r_pan;
    logic [PAN_W-1:0]  r_width;
    logic [IW-1:0]     r_idx;
    logic [LFO_W-1:0]  r_lfo_start_l;
    logic [LFO_W-1:0]  r_lfo_start_r;
    logic [LFO_W-1:0]  r_lfo_end_l;
    logic [LFO_W-1:0]  r_lfo_end_r;
    logic              r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;

    t_ctrl             ctrl;
    t_stat             stat;
    t_coef             coef_l;
    t_coef             coef_r;
    logic              accept;
    logic              emit;
    logic              div_more_l;
    logic              div_more_r;
    logic signed [XW-1:0] x_l;
    logic signed [XW-1:0] x_r;
    logic [SAMPLE_BITS-1:0] sat_l;
    logic [SAMPLE_BITS-1:0] sat_r;

    // Input beat is taken only in the wait step.
    assign o_stall = (ctrl.op != OP_LOAD) | ~i_rst_n;
    assign accept  = i_valid & ~o_stall;
    assign emit    = (ctrl.op == OP_EMIT) & ~(r_out_valid & i_stall);

    // Status for the sequencer's jumps.
    always_comb begin
        stat.item_valid = i_valid;
        stat.widen      = r_widen;
        stat.autopan    = r_autopan;
        stat.div_more   = div_more_l | div_more_r;
        stat.out_busy   = r_out_valid & i_stall;
    end

    // Left takes cos (mirrored table index) and pan weight p; right takes
    // sin and weight 127-p.
    always_comb begin
        coef_l.gain      = SIN_TABLE[~r_pan];
        coef_l.weight    = r_pan;
        coef_l.width     = r_width;
        coef_l.lfo_start = r_lfo_start_l;
        coef_l.lfo_end   = r_lfo_end_l;
        coef_r.gain      = SIN_TABLE[r_pan];
        coef_r.weight    = ~r_pan;
        coef_r.width     = r_width;
        coef_r.lfo_start = r_lfo_start_r;
        coef_r.lfo_end   = r_lfo_end_r;
    end

    stwa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    stwa_lane #(
        .BLOCK_LEN   (BLOCK_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .i_clk      (i_clk),
        .i_op       (ctrl.op),
        .i_sample   (i_left_in),
        .i_other    (x_r),
        .i_coef     (coef_l),
        .i_idx      (r_idx),
        .o_x        (x_l),
        .o_sat      (sat_l),
        .o_div_more (div_more_l)
    );

    stwa_lane #(
        .BLOCK_LEN   (BLOCK_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .i_clk      (i_clk),
        .i_op       (ctrl.op),
        .i_sample   (i_right_in),
        .i_other    (x_l),
        .i_coef     (coef_r),
        .i_idx      (r_idx),
        .o_x        (x_r),
        .o_sat      (sat_r),
        .o_div_more (div_more_r)
    );

    // Settings, block position, LFO endpoints and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widen       <= 1'b0;
            r_autopan     <= 1'b1;
            r_pan         <= PAN_W'(64);
            r_width       <= '0;
            r_idx         <= '0;
            r_lfo_start_l <= '0;
            r_lfo_start_r <= '0;
            r_lfo_end_l   <= '0;
            r_lfo_end_r   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDEN:   r_widen   <= i_cfg_data[0];
                    CFG_AUTOPAN: r_autopan <= i_cfg_data[0];
                    CFG_PAN:     r_pan     <= i_cfg_data;
                    CFG_WIDTH:   r_width   <= i_cfg_data;
                endcase
            end
            // At block start the LFO endpoints shift in the new end values.
            if (accept && r_autopan && (r_idx == '0)) begin
                r_lfo_start_l <= r_lfo_end_l;
                r_lfo_start_r <= r_lfo_end_r;
                r_lfo_end_l   <= i_lfo_left_next;
                r_lfo_end_r   <= i_lfo_right_next;
            end
            // The block position advances once per finished pair.
            if (emit) begin
                if (r_idx == IW'(BLOCK_LEN - 1)) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output beat payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_left_out  <= sat_l;
            r_right_out <= sat_r;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

`default_nettype wire

/* bench/stereo_widener_autopan_tb.sv */
// Self-checking testbench for the stereo widener with auto-pan: directed table, random phases.
module stereo_widener_autopan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stwa_pkg::*;

    localparam int SW          = 24;
    localparam int BLOCK       = 128;
    localparam int SETTLE      = 40;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIRECTED  = 18;

    localparam logic [SW-1:0] MAX_S = 24'h7FFFFF;
    localparam logic [SW-1:0] MIN_S = 24'h800000;
    localparam longint SAT_HI = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
    } t_pair;

    typedef struct packed {
        bit              widen;
        bit              autopan;
        bit [PAN_W-1:0]  pan;
        bit [PAN_W-1:0]  width;
        bit [SW-1:0]     left;
        bit [SW-1:0]     right;
        bit [LFO_W-1:0]  lfo_l;
        bit [LFO_W-1:0]  lfo_r;
        bit              known;
        bit [SW-1:0]     want_l;
        bit [SW-1:0]     want_r;
    } t_stim_row;

    // Directed rows: setting, input beat, and the result where it is obvious.
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // Fresh block after reset: the LFO start point is zero, so the gain is zero.
        '{0, 1,  64,   0, MAX_S, MIN_S, 16'hFFFF, 16'hFFFF, 1, 24'h0, 24'h0},
        '{0, 1,  64,   0, MAX_S, MIN_S, 16'h0000, 16'h0000, 0, 24'h0, 24'h0},
        '{0, 1,  64,   0, 24'hFFFFFF, 24'h000001, 16'h1234, 16'h8001, 0, 24'h0, 24'h0},
        // Both stages off: straight pass-through.
        '{0, 0,  64,   0, MAX_S, MIN_S, 16'h0000, 16'h0000, 1, MAX_S, MIN_S},
        '{0, 0,  64,   0, MIN_S, MAX_S, 16'hFFFF, 16'hFFFF, 1, MIN_S, MAX_S},
        '{0, 0,  64,   0, 24'hFFFFFF, 24'h000000, 16'h0000, 16'h0000, 1, 24'hFFFFFF, 24'h0},
        '{1, 0,   0,   0, MAX_S, MAX_S, 16'h0000, 16'h0000, 0, 24'h0, 24'h0},
        // Hard pan with full width: one side has zero gain, the other saturates.
        '{1, 0, 127, 127, MAX_S, MIN_S, 16'h0000, 16'h0000, 1, 24'h0, MIN_S},
        '{1, 0, 127, 127, MIN_S, MAX_S, 16'h0000, 16'h0000, 1, 24'h0, MAX_S},
        '{1, 0,   0, 127, MAX_S, MIN_S, 16'h0000, 16'h0000, 1, MAX_S, 24'h0},
        '{1, 0,  64,  64, 24'h12D687, 24'h8B3C4F, 16'h0000, 16'h0000, 0, 24'h0, 24'h0},
        '{1, 0,  64,   0, MAX_S, MIN_S, 16'h0000, 16'h0000, 0, 24'h0, 24'h0},
        '{0, 1, 127,   0, MAX_S, MAX_S, 16'hFFFF, 16'h0000, 0, 24'h0, 24'h0},
        '{0, 1,   0,   0, MIN_S, MIN_S, 16'h0000, 16'hFFFF, 0, 24'h0, 24'h0},
        '{1, 1, 100,  50, 24'h3A5C11, 24'hC0FFEE, 16'h8000, 16'h4000, 0, 24'h0, 24'h0},
        '{1, 1,  27, 127, MIN_S, MAX_S, 16'hFFFF, 16'hFFFF, 0, 24'h0, 24'h0},
        '{1, 1, 127,   0, MAX_S, 24'h000000, 16'h0000, 16'h0000, 0, 24'h0, 24'h0},
        '{1, 1,   0, 127, 24'h000001, 24'hFFFFFF, 16'h0000, 16'h0000, 0, 24'h0, 24'h0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [SW-1:0]          i_left_in;
    logic [SW-1:0]          i_right_in;
    logic [LFO_W-1:0]       i_lfo_left_next;
    logic [LFO_W-1:0]       i_lfo_right_next;
    logic                   o_valid;
    logic                   i_stall;
    logic [SW-1:0]          o_left_out;
    logic [SW-1:0]          o_right_out;
    logic                   i_cfg_we;
    logic [1:0]             i_cfg_idx;
    logic [PAN_W-1:0]       i_cfg_data;

    // Mirror of the block's settings and block/LFO state.
    bit                     widen_on;
    bit                     autopan_on;
    logic [PAN_W-1:0]       pan_pos;
    logic [PAN_W-1:0]       width_amt;
    int                     blk_pos;
    logic [LFO_W-1:0]       lfo_l_start;
    logic [LFO_W-1:0]       lfo_r_start;
    logic [LFO_W-1:0]       lfo_l_stop;
    logic [LFO_W-1:0]       lfo_r_stop;

    t_pair                  pending_pairs[$];
    int                     mismatch_count;
    bit                     steady;
    bit                     hold_req;

    stereo_widener_autopan #(
        .BLOCK_LEN   (BLOCK),
        .SAMPLE_BITS (SW)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_left_in        (i_left_in),
        .i_right_in       (i_right_in),
        .i_lfo_left_next  (i_lfo_left_next),
        .i_lfo_right_next (i_lfo_right_next),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Quarter-sine gain in Q0.15 from a truncating Taylor series in Q2.30.
    function automatic longint sine_gain(int unsigned k);
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        int unsigned n;
        kk = k;
        x = (kk * QUARTER_TURN_Q30) / 127;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / (2 * n * (2 * n + 1));
            if (n % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        acc = (acc + 16384) >> 15;
        return (acc > 32767) ? 32767 : longint'(acc);
    endfunction

    // Divide with rounding to nearest, ties away from zero.
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [SW-1:0] clamp_sample(longint v);
        longint c;
        c = (v > SAT_HI) ? SAT_HI : (v < SAT_LO) ? SAT_LO : v;
        return c[SW-1:0];
    endfunction

    // Linear LFO ramp across the block, Q0.16.
    function automatic longint lfo_ramp(logic [LFO_W-1:0] a, logic [LFO_W-1:0] b, int pos);
        return (longint'(a) * (BLOCK - pos) + longint'(b) * pos) / BLOCK;
    endfunction

    // Expected output pair for one accepted beat; advances the block state.
    function automatic t_pair widen_pan_pair(logic [SW-1:0] l_in, logic [SW-1:0] r_in,
                                             logic [LFO_W-1:0] lfo_l, logic [LFO_W-1:0] lfo_r);
        longint l;
        longint r;
        longint s;
        longint d;
        longint side;
        longint p;
        longint w;
        int pos;
        t_pair res;
        l = longint'(signed'(l_in));
        r = longint'(signed'(r_in));
        p = pan_pos;
        w = width_amt;
        pos = blk_pos;
        if (widen_on) begin
            s = l + r;
            d = l - r;
            side = 4 * w * d;
            l = round_div((127 * s + side) * sine_gain(127 - p), 254 * 32768);
            r = round_div((127 * s - side) * sine_gain(p), 254 * 32768);
        end
        if (autopan_on) begin
            // New block: the old end point becomes the start, the new one is latched.
            if (pos == 0) begin
                lfo_l_start = lfo_l_stop;
                lfo_r_start = lfo_r_stop;
                lfo_l_stop = lfo_l;
                lfo_r_stop = lfo_r;
            end
            l = round_div(l * lfo_ramp(lfo_l_start, lfo_l_stop, pos) * p, 65536 * 127);
            r = round_div(r * lfo_ramp(lfo_r_start, lfo_r_stop, pos) * (127 - p), 65536 * 127);
        end
        blk_pos = (blk_pos + 1) % BLOCK;
        res.left = clamp_sample(l);
        res.right = clamp_sample(r);
        return res;
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return MAX_S;
            1: return MIN_S;
            2: return SW'($urandom_range(0, 255));
            3: return -SW'($urandom_range(0, 255));
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [LFO_W-1:0] rand_lfo();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return LFO_W'($urandom);
        endcase
    endfunction

    // One register write; the enable stays high for back-to-back writes.
    task automatic write_reg(input t_cfg_reg idx, input logic [PAN_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_WIDEN:   widen_on = data[0];
            CFG_AUTOPAN: autopan_on = data[0];
            CFG_PAN:     pan_pos = data;
            CFG_WIDTH:   width_amt = data;
        endcase
    endtask

    // Drain the block, then load all four registers. Enable writes carry
    // random upper bits, which the block must drop.
    task automatic apply_setting(input bit w, input bit a,
                                 input logic [PAN_W-1:0] p, input logic [PAN_W-1:0] wd);
        i_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        write_reg(CFG_WIDEN, {6'($urandom), w});
        write_reg(CFG_AUTOPAN, {6'($urandom), a});
        write_reg(CFG_PAN, p);
        write_reg(CFG_WIDTH, wd);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one input beat, record its expected result, then maybe idle.
    task automatic send_pair(input logic [SW-1:0] l, input logic [SW-1:0] r,
                             input logic [LFO_W-1:0] ln, input logic [LFO_W-1:0] rn,
                             input bit known, input t_pair want);
        t_pair calc;
        int gap;
        int pick;
        i_valid <= 1'b1;
        i_left_in <= l;
        i_right_in <= r;
        i_lfo_left_next <= ln;
        i_lfo_right_next <= rn;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        calc = widen_pan_pair(l, r, ln, rn);
        pending_pairs.push_back(known ? want : calc);
        pick = $urandom_range(0, 99);
        if (steady || hold_req || pick < 70) gap = 0;
        else if (pick < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 50);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [SW-1:0] got,
                               input logic [SW-1:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endtask

    // Output side: compare every accepted beat with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_pair want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_pairs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected output beat: left %0d, right %0d",
                             $signed(o_left_out), $signed(o_right_out));
            end else begin
                want = pending_pairs.pop_front();
                check_field("left_out", o_left_out, want.left);
                check_field("right_out", o_right_out, want.right);
            end
        end
    end

    // Receiver stalls: mostly short, a few long, and one long hold on request.
    initial begin : receiver
        int r;
        int n;
        i_stall <= 1'b0;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                i_stall <= (r >= 55);
                if (r < 55) n = $urandom_range(1, 20);
                else if (r < 90) n = $urandom_range(1, 3);
                else n = $urandom_range(10, 40);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Sender: reset, directed table, then random phases.
    initial begin : sender
        int ph;
        int k;
        bit w;
        bit a;
        logic [PAN_W-1:0] p;
        logic [PAN_W-1:0] wd;
        t_stim_row row;
        t_pair typed;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_left_in <= '0;
        i_right_in <= '0;
        i_lfo_left_next <= '0;
        i_lfo_right_next <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_WIDEN;
        i_cfg_data <= '0;
        mismatch_count = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        widen_on = 1'b0;
        autopan_on = 1'b1;
        pan_pos = 7'd64;
        width_amt = 7'd0;
        blk_pos = 0;
        lfo_l_start = '0;
        lfo_r_start = '0;
        lfo_l_stop = '0;
        lfo_r_stop = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; registers are rewritten only when the setting changes.
        for (k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED[k];
            if (row.widen != widen_on || row.autopan != autopan_on ||
                row.pan != pan_pos || row.width != width_amt)
                apply_setting(row.widen, row.autopan, row.pan, row.width);
            typed.left = row.want_l;
            typed.right = row.want_r;
            send_pair(row.left, row.right, row.lfo_l, row.lfo_r, row.known, typed);
        end

        // Random phases, the first few at the extremes of the settings.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin w = 1; a = 1; p = 127; wd = 127; end
                1: begin w = 0; a = 0; p = 0;   wd = 0;   end
                2: begin w = 1; a = 1; p = 0;   wd = 127; end
                3: begin w = 1; a = 0; p = 127; wd = 0;   end
                default: begin
                    w = $urandom_range(0, 1);
                    a = (ph % 3 != 1);
                    p = $urandom_range(0, 127);
                    wd = $urandom_range(0, 127);
                end
            endcase
            apply_setting(w, a, p, wd);
            steady = ($urandom_range(0, 3) == 0);
            hold_req = (ph == 2);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_pair(rand_sample(), rand_sample(), rand_lfo(), rand_lfo(), 1'b0, '0);
                // Once, stop offering until every outstanding result is back.
                if (ph == 5 && k == PHASE_ITEMS / 2) begin
                    i_valid <= 1'b0;
                    while (pending_pairs.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
            end
        end

        i_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pairs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* stereo_widener_autopan.f */
rtl/stwa_pkg.sv
rtl/stwa_seq.sv
rtl/stwa_lane.sv
rtl/stereo_widener_autopan.sv
bench/stereo_widener_autopan_tb.sv
